>>> hw/rtl/sha256_byte_stream_hasher_macros.svh
// Assertion macros shared by the hasher RTL.
`ifndef SHA256_BYTE_STREAM_HASHER_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SHA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SHA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/sha_pkg.sv
// Types, constants and round functions of the SHA-256 hasher.
package sha_pkg;

	localparam logic OP_ABSORB = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	localparam logic [7:0] PAD_MARK = 8'h80;

	// [0] is the most significant digest word
	typedef logic [7:0][31:0] hash_t;

	typedef struct packed {
		logic       shift_byte;
		logic [7:0] byte_val;
		logic       round_en;
		logic [5:0] round_idx;
		logic       load_vars;
		logic       add_hash;
		logic       init_hash;
		logic       dump;
	} ctrl_t;

	localparam hash_t HASH_IV = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

endpackage

>>> hw/rtl/sha_in_if.sv
// Input channel: one absorb or finish request per transfer.
interface sha_in_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] data_byte;

	modport source (output valid, output op, output data_byte, input ready);
	modport sink (input valid, input op, input data_byte, output ready);
endinterface

>>> hw/rtl/sha_out_if.sv
// Output channel: one digest word per transfer.
interface sha_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source (output valid, output digest_word, output word_index, output last_word,
		input ready);
	modport sink (input valid, input digest_word, input word_index, input last_word,
		output ready);
endinterface

>>> hw/rtl/sha_sched.sv
// Block buffer and message schedule window, filled a byte at a time.
module sha_sched (
	input  logic           clk,
	input  sha_pkg::ctrl_t ctrl,
	output logic [31:0]    w_cur
);
	import sha_pkg::*;

	// [15] holds the oldest word; bytes enter at the low end
	logic [15:0][31:0] w_q;
	logic [31:0]       w_next;

	assign w_cur  = w_q[15];
	assign w_next = w_q[15] + small_sigma0(w_q[14]) + w_q[6] + small_sigma1(w_q[1]);

	always_ff @(posedge clk) begin
		if (ctrl.shift_byte) begin
			w_q <= {w_q[15][23:0], w_q[14:0], ctrl.byte_val};
		end else if (ctrl.round_en) begin
			w_q <= {w_q[14:0], w_next};
		end
	end
endmodule

>>> hw/rtl/sha_round.sv
// Working variables, round datapath and chaining hash value.
module sha_round (
	input  logic           clk,
	input  logic           arst_n,
	input  sha_pkg::ctrl_t ctrl,
	input  logic [31:0]    w_cur,
	output sha_pkg::hash_t hash
);
	import sha_pkg::*;

	hash_t       hash_q;
	hash_t       v_q;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] ch;
	logic [31:0] maj;

	assign hash = hash_q;

	// v_q[0..7] = a..h
	assign ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1  = v_q[7] + big_sigma1(v_q[4]) + ch + ROUND_K[ctrl.round_idx] + w_cur;
	assign t2  = big_sigma0(v_q[0]) + maj;

	always_ff @(posedge clk) begin
		if (ctrl.load_vars) begin
			v_q <= hash_q;
		end else if (ctrl.round_en) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= HASH_IV;
		end else if (ctrl.init_hash) begin
			hash_q <= HASH_IV;
		end else if (ctrl.add_hash) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= hash_q[i] + v_q[i];
			end
		end
	end
endmodule

>>> hw/rtl/sha_ctrl.sv
// Sequencer: byte intake, padding, round count and block bookkeeping.
module sha_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	sha_in_if.sink         msg,
	input  logic           out_free,
	output sha_pkg::ctrl_t ctrl
);
	import sha_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PAD  = 3'd1;
	localparam logic [2:0] S_COMP = 3'd2;
	localparam logic [2:0] S_ADD  = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	localparam logic [5:0] LEN_POS  = 6'd56;
	localparam logic [5:0] LAST_POS = 6'd63;

	logic [2:0]  state_q;
	logic [5:0]  pos_q;
	logic [5:0]  round_q;
	logic        mark_q;
	logic        tail_q;
	logic        final_q;
	logic [63:0] len_q;
	logic [54:0] blocks_q;

	logic xfer;
	logic len_byte;

	assign msg.ready = (state_q == S_IDLE);
	assign xfer      = msg.valid && msg.ready;
	// length goes in the last eight bytes of the tail block
	assign len_byte  = mark_q && tail_q && (pos_q >= LEN_POS);

	always_comb begin
		ctrl = '0;
		ctrl.round_idx = round_q;
		case (state_q)
			S_IDLE: begin
				if (xfer && msg.op == OP_ABSORB) begin
					ctrl.shift_byte = 1'b1;
					ctrl.byte_val   = msg.data_byte;
					ctrl.load_vars  = (pos_q == LAST_POS);
				end
			end
			S_PAD: begin
				ctrl.shift_byte = 1'b1;
				if (!mark_q) begin
					ctrl.byte_val = PAD_MARK;
				end else if (len_byte) begin
					ctrl.byte_val = len_q[63:56];
				end else begin
					ctrl.byte_val = 8'h00;
				end
				ctrl.load_vars = (pos_q == LAST_POS);
			end
			S_COMP: ctrl.round_en = 1'b1;
			S_ADD:  ctrl.add_hash = 1'b1;
			S_DONE: begin
				ctrl.dump      = out_free;
				ctrl.init_hash = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			pos_q    <= '0;
			round_q  <= '0;
			mark_q   <= 1'b0;
			tail_q   <= 1'b0;
			final_q  <= 1'b0;
			blocks_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (xfer) begin
						if (msg.op == OP_ABSORB) begin
							final_q <= 1'b0;
							pos_q   <= pos_q + 6'd1;
							if (pos_q == LAST_POS) begin
								state_q <= S_COMP;
							end
						end else begin
							final_q <= 1'b1;
							mark_q  <= 1'b0;
							tail_q  <= (pos_q < LEN_POS);
							state_q <= S_PAD;
						end
					end
				end
				S_PAD: begin
					mark_q <= 1'b1;
					pos_q  <= pos_q + 6'd1;
					if (pos_q == LAST_POS) begin
						state_q <= S_COMP;
					end
				end
				S_COMP: begin
					round_q <= round_q + 6'd1;
					if (round_q == LAST_POS) begin
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					if (!final_q) begin
						blocks_q <= blocks_q + 55'd1;
						state_q  <= S_IDLE;
					end else if (tail_q) begin
						state_q <= S_DONE;
					end else begin
						// marker spilled into this block; length needs one more
						tail_q  <= 1'b1;
						state_q <= S_PAD;
					end
				end
				S_DONE: begin
					if (out_free) begin
						blocks_q <= '0;
						pos_q    <= '0;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// total bits: whole blocks times 512 plus buffered bytes times 8
	always_ff @(posedge clk) begin
		if (xfer && msg.op == OP_FINISH) begin
			len_q <= {blocks_q, pos_q, 3'b000};
		end else if (state_q == S_PAD && len_byte) begin
			len_q <= {len_q[55:0], 8'h00};
		end
	end
endmodule

>>> hw/rtl/sha_out.sv
// Digest holding register, drained one word per transfer.
module sha_out (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           dump,
	input  sha_pkg::hash_t hash,
	output logic           out_free,
	sha_out_if.source      digest
);
	import sha_pkg::*;

	localparam logic [2:0] LAST_IDX = 3'd7;

	hash_t      words_q;
	logic [2:0] idx_q;
	logic       busy_q;
	logic       xfer;

	assign xfer               = digest.valid && digest.ready;
	assign out_free           = !busy_q;
	assign digest.valid       = busy_q;
	assign digest.digest_word = words_q[0];
	assign digest.word_index  = idx_q;
	assign digest.last_word   = (idx_q == LAST_IDX);

	always_ff @(posedge clk) begin
		if (dump) begin
			words_q <= hash;
		end else if (xfer) begin
			words_q <= {32'd0, words_q[7:1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (dump) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (xfer) begin
			idx_q <= idx_q + 3'd1;
			if (idx_q == LAST_IDX) begin
				busy_q <= 1'b0;
			end
		end
	end
endmodule

>>> hw/rtl/sha256_byte_stream_hasher.sv
// Top level of the SHA-256 byte stream hasher.
// Channel msg takes one request per transfer: op absorb appends data_byte to
// the message, op finish pads the message and produces its digest.
// Channel digest returns eight transfers per finish, word_index 0 (most
// significant) to 7, with last_word set on the eighth.
// An absorb is taken only while the sequencer is idle; the 64th byte of a block
// then starts the compression (64 rounds of the single round unit, one chaining add).
// A finish pads the tail block through the byte path (64 - fill bytes) and
// compresses it, and pads and compresses one more block when fewer than nine
// bytes are free in the tail block. The digest is then loaded into the
// holding register, once the previous digest has drained, and its first
// word is offered the cycle after that.
// Digest words sit in a holding register, so absorbs of the next message go
// on while the receiver stalls; the digest of a second finish waits until all
// eight words have gone.
// Reset loads the standard initial hash value and empties the buffer and bit
// count; no clearing pass is needed.
module sha256_byte_stream_hasher (
	input  logic      clk,
	input  logic      arst_n,
	sha_in_if.sink    msg,
	sha_out_if.source digest
);
	import sha_pkg::*;

`include "sha256_byte_stream_hasher_macros.svh"

	ctrl_t       ctrl;
	hash_t       hash;
	logic [31:0] w_cur;
	logic        out_free;
	logic        dig_xfer;

	assign dig_xfer = digest.valid && digest.ready;

	sha_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.msg      (msg),
		.out_free (out_free),
		.ctrl     (ctrl)
	);

	sha_sched u_sched (
		.clk   (clk),
		.ctrl  (ctrl),
		.w_cur (w_cur)
	);

	sha_round u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.w_cur  (w_cur),
		.hash   (hash)
	);

	sha_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.dump     (ctrl.dump),
		.hash     (hash),
		.out_free (out_free),
		.digest   (digest)
	);

	`SHA_ASSERT_IMP(a_no_accept_in_rounds, ctrl.round_en, !msg.ready, "taken mid-compression")
	`SHA_ASSERT_IMP(a_dump_when_empty, ctrl.dump, !digest.valid, "digest overwritten")
	`SHA_ASSERT_NXT(a_burst_continues, dig_xfer && !digest.last_word, digest.valid, "burst broken")
	`SHA_ASSERT_NXT(a_burst_ends, dig_xfer && digest.last_word, !digest.valid, "extra digest word")
endmodule
